// File: rtl/pli_pkg.sv
// Package: payload structs, command/status types and constants for the interpolator.
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  localparam int MAX_POINTS_DEF = 128;
  localparam int IDX_W          = 7;
  localparam int DATA_W         = 32;
  localparam int PIU_W          = 8;
  localparam int LIMIT_W        = 31;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 31;
  localparam int DIV_STEPS      = 32;
  localparam int CNT_W          = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT  = 1'b1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BEFORE   = 2'd1;
  localparam logic [1:0] REGION_AFTER    = 2'd2;
  localparam logic [1:0] REGION_EMPTY    = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         point_index;
    logic [DATA_W-1:0]        point_time;
    logic signed [DATA_W-1:0] point_value;
    logic [DATA_W-1:0]        query_time;
  } pli_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               region;
  } pli_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SEARCH,
    S_COMPARE,
    S_MUL,
    S_DIV,
    S_ADD,
    S_FINISH
  } pli_state_e;

  typedef enum logic [1:0] {
    ADDR_FIRST,
    ADDR_LAST,
    ADDR_MID
  } addr_sel_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PREP,
    OP_MUL,
    OP_DIV
  } dp_op_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_EMPTY,
    RES_FIRST_PT,
    RES_LAST_PT,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic      load;
    logic      capture;
    logic      rd_en;
    addr_sel_e addr_sel;
    logic      set_lo;
    logic      set_hi;
    dp_op_e    op;
    res_sel_e  res_sel;
    logic      push;
  } pli_cmd_t;

  typedef struct packed {
    logic empty;
    logic t_le_rd;
    logic t_ge_rd;
    logic span_gt1;
    logic out_busy;
  } pli_status_t;

endpackage

`default_nettype wire

// File: rtl/pli_table.sv
// Breakpoint table: time and value memories, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pli_table #(
  parameter int DEPTH = pli_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [AW-1:0]                    wr_addr_i,
  input  wire logic [pli_pkg::DATA_W-1:0]        wr_time_i,
  input  wire logic signed [pli_pkg::DATA_W-1:0] wr_value_i,
  input  wire logic                             rd_en_i,
  input  wire logic [AW-1:0]                    rd_addr_i,
  output logic [pli_pkg::DATA_W-1:0]             rd_time_o,
  output logic signed [pli_pkg::DATA_W-1:0]      rd_value_o
);

  logic [pli_pkg::DATA_W-1:0]        time_mem  [DEPTH];
  logic signed [pli_pkg::DATA_W-1:0] value_mem [DEPTH];
  logic [pli_pkg::DATA_W-1:0]        rd_time_q;
  logic signed [pli_pkg::DATA_W-1:0] rd_value_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[wr_addr_i]  <= wr_time_i;
      value_mem[wr_addr_i] <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_time_q  <= time_mem[rd_addr_i];
      rd_value_q <= value_mem[rd_addr_i];
    end
  end

  assign rd_time_o  = rd_time_q;
  assign rd_value_o = rd_value_q;

endmodule

`default_nettype wire

// File: rtl/pli_ctrl.sv
// Controller: sequences load, endpoint checks, binary search, multiply and divide.
`timescale 1ns / 1ps
`default_nettype none

module pli_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_kind_i,
  input  wire pli_pkg::pli_status_t status_i,
  output logic                      in_stall_o,
  output pli_pkg::pli_cmd_t         cmd_o
);

  pli_pkg::pli_state_e        state_q, state_d;
  logic [pli_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       div_last;

  assign div_last = (cnt_q == pli_pkg::CNT_W'(pli_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pli_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (state_q == pli_pkg::S_MUL) begin
      cnt_d = '0;
    end else if (state_q == pli_pkg::S_DIV) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pli_pkg::S_IDLE: begin
        if (in_valid_i && (in_kind_i == pli_pkg::KIND_QUERY)) begin
          state_d = status_i.empty ? pli_pkg::S_FINISH : pli_pkg::S_FIRST;
        end
      end
      pli_pkg::S_FIRST:     state_d = pli_pkg::S_CHK_FIRST;
      pli_pkg::S_CHK_FIRST: state_d = status_i.t_le_rd ? pli_pkg::S_FINISH : pli_pkg::S_CHK_LAST;
      pli_pkg::S_CHK_LAST:  state_d = status_i.t_ge_rd ? pli_pkg::S_FINISH : pli_pkg::S_SEARCH;
      pli_pkg::S_SEARCH:    state_d = status_i.span_gt1 ? pli_pkg::S_COMPARE : pli_pkg::S_MUL;
      pli_pkg::S_COMPARE:   state_d = pli_pkg::S_SEARCH;
      pli_pkg::S_MUL:       state_d = pli_pkg::S_DIV;
      pli_pkg::S_DIV:       state_d = div_last ? pli_pkg::S_ADD : pli_pkg::S_DIV;
      pli_pkg::S_ADD:       state_d = pli_pkg::S_FINISH;
      pli_pkg::S_FINISH:    state_d = status_i.out_busy ? pli_pkg::S_FINISH : pli_pkg::S_IDLE;
      default:              state_d = pli_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o     = (state_q != pli_pkg::S_IDLE);
    cmd_o          = '0;
    cmd_o.addr_sel = pli_pkg::ADDR_FIRST;
    cmd_o.op       = pli_pkg::OP_NONE;
    cmd_o.res_sel  = pli_pkg::RES_HOLD;
    unique case (state_q)
      pli_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == pli_pkg::KIND_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            if (status_i.empty) begin
              cmd_o.res_sel = pli_pkg::RES_EMPTY;
            end
          end
        end
      end
      pli_pkg::S_FIRST: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = pli_pkg::ADDR_FIRST;
      end
      pli_pkg::S_CHK_FIRST: begin
        if (status_i.t_le_rd) begin
          cmd_o.res_sel = pli_pkg::RES_FIRST_PT;
        end else begin
          // slot 0 becomes the low bracket; fetch the last point
          cmd_o.set_lo   = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = pli_pkg::ADDR_LAST;
        end
      end
      pli_pkg::S_CHK_LAST: begin
        if (status_i.t_ge_rd) begin
          cmd_o.res_sel = pli_pkg::RES_LAST_PT;
        end else begin
          cmd_o.set_hi = 1'b1;
        end
      end
      pli_pkg::S_SEARCH: begin
        if (status_i.span_gt1) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = pli_pkg::ADDR_MID;
        end else begin
          cmd_o.op = pli_pkg::OP_PREP;
        end
      end
      pli_pkg::S_COMPARE: begin
        cmd_o.set_lo = status_i.t_ge_rd;
        cmd_o.set_hi = !status_i.t_ge_rd;
      end
      pli_pkg::S_MUL: cmd_o.op = pli_pkg::OP_MUL;
      pli_pkg::S_DIV: cmd_o.op = pli_pkg::OP_DIV;
      pli_pkg::S_ADD: cmd_o.res_sel = pli_pkg::RES_INTERP;
      pli_pkg::S_FINISH: cmd_o.push = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pli_datapath.sv
// Datapath: config registers, table, search brackets, multiply, restoring divider, clamp.
`timescale 1ns / 1ps
`default_nettype none

module pli_datapath #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pli_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pli_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire pli_pkg::pli_in_t                  in_data_i,
  input  wire logic                              out_stall_i,
  input  wire pli_pkg::pli_cmd_t                 cmd_i,
  output pli_pkg::pli_status_t                   status_o,
  output logic                                   out_valid_o,
  output pli_pkg::pli_out_t                      out_data_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > pli_pkg::PIU_W) ? NW : pli_pkg::PIU_W;
  localparam int XW = (AW > pli_pkg::IDX_W) ? AW : pli_pkg::IDX_W;
  localparam int DW = pli_pkg::DATA_W;

  // configuration
  logic [pli_pkg::PIU_W-1:0]   piu_q;
  logic [pli_pkg::LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q   <= '0;
      limit_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pli_pkg::CFG_POINTS_IN_USE: piu_q   <= cfg_data_i[pli_pkg::PIU_W-1:0];
        pli_pkg::CFG_OUTPUT_LIMIT:  limit_q <= cfg_data_i[pli_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective point count, clipped to the table depth
  logic [CW-1:0] piu_x, n_x, last_x;
  logic [AW-1:0] last_idx;

  assign piu_x    = CW'(piu_q);
  assign n_x      = (piu_x > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : piu_x;
  assign last_x   = n_x - CW'(1);
  assign last_idx = last_x[AW-1:0];

  // table write on load transactions
  logic [XW-1:0] idx_x;
  logic          idx_ok, tbl_we;

  assign idx_x  = XW'(in_data_i.point_index);
  assign idx_ok = ({1'b0, idx_x} < (XW + 1)'(MAX_POINTS));
  assign tbl_we = cmd_i.load && idx_ok;

  // search brackets
  logic [DW-1:0]        t_q;
  logic [AW-1:0]        lo_idx_q, hi_idx_q, rd_idx_q, rd_addr;
  logic [DW-1:0]        lo_time_q, hi_time_q;
  logic signed [DW-1:0] lo_val_q, hi_val_q;
  logic [DW-1:0]        rd_time;
  logic signed [DW-1:0] rd_value;
  logic [AW:0]          idx_sum, span;
  logic [AW-1:0]        mid;

  assign idx_sum = {1'b0, lo_idx_q} + {1'b0, hi_idx_q};
  assign mid     = idx_sum[AW:1];
  assign span    = {1'b0, hi_idx_q} - {1'b0, lo_idx_q};

  always_comb begin
    unique case (cmd_i.addr_sel)
      pli_pkg::ADDR_FIRST: rd_addr = '0;
      pli_pkg::ADDR_LAST:  rd_addr = last_idx;
      pli_pkg::ADDR_MID:   rd_addr = mid;
      default:             rd_addr = '0;
    endcase
  end

  pli_table #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_table (
    .clk_i      (clk_i),
    .we_i       (tbl_we),
    .wr_addr_i  (idx_x[AW-1:0]),
    .wr_time_i  (in_data_i.point_time),
    .wr_value_i (in_data_i.point_value),
    .rd_en_i    (cmd_i.rd_en),
    .rd_addr_i  (rd_addr),
    .rd_time_o  (rd_time),
    .rd_value_o (rd_value)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q <= in_data_i.query_time;
    end
    if (cmd_i.rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (cmd_i.set_lo) begin
      lo_idx_q  <= rd_idx_q;
      lo_time_q <= rd_time;
      lo_val_q  <= rd_value;
    end
    if (cmd_i.set_hi) begin
      hi_idx_q  <= rd_idx_q;
      hi_time_q <= rd_time;
      hi_val_q  <= rd_value;
    end
  end

  // interpolation: |d| * num / den, one quotient bit per cycle
  logic [DW-1:0]       mag_q, num_q, den_q, rem_q, quo_q;
  logic                neg_q;
  logic signed [DW:0]  diff;
  logic [DW:0]         diff_abs;
  logic [2*DW-1:0]     prod;
  logic [DW:0]         rem_sh, rem_sub;
  logic                rem_ge;

  assign diff     = {hi_val_q[DW-1], hi_val_q} - {lo_val_q[DW-1], lo_val_q};
  assign diff_abs = diff[DW] ? -diff : diff;
  assign prod     = {{DW{1'b0}}, mag_q} * {{DW{1'b0}}, num_q};
  assign rem_sh   = {rem_q, quo_q[DW-1]};
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign rem_ge   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      pli_pkg::OP_PREP: begin
        neg_q <= diff[DW];
        mag_q <= diff_abs[DW-1:0];
        num_q <= t_q - lo_time_q;
        den_q <= hi_time_q - lo_time_q;
      end
      pli_pkg::OP_MUL: begin
        rem_q <= prod[2*DW-1:DW];
        quo_q <= prod[DW-1:0];
      end
      pli_pkg::OP_DIV: begin
        rem_q <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_q <= {quo_q[DW-2:0], rem_ge};
      end
      default: ;
    endcase
  end

  // result before clamp
  logic signed [DW+1:0] val_q, vlo_x, step_x, interp;
  logic [1:0]           region_q;

  assign vlo_x  = {{2{lo_val_q[DW-1]}}, lo_val_q};
  assign step_x = {2'b00, quo_q};
  assign interp = neg_q ? (vlo_x - step_x) : (vlo_x + step_x);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res_sel)
      pli_pkg::RES_EMPTY: begin
        val_q    <= '0;
        region_q <= pli_pkg::REGION_EMPTY;
      end
      pli_pkg::RES_FIRST_PT: begin
        val_q    <= {{2{rd_value[DW-1]}}, rd_value};
        region_q <= pli_pkg::REGION_BEFORE;
      end
      pli_pkg::RES_LAST_PT: begin
        val_q    <= {{2{rd_value[DW-1]}}, rd_value};
        region_q <= pli_pkg::REGION_AFTER;
      end
      pli_pkg::RES_INTERP: begin
        val_q    <= interp;
        region_q <= pli_pkg::REGION_INTERIOR;
      end
      default: ;
    endcase
  end

  // clamp and output register
  logic signed [DW+1:0] lim_x, lim_neg, clamped;
  logic                 out_valid_q;
  pli_pkg::pli_out_t    out_q;

  assign lim_x   = {3'b000, limit_q};
  assign lim_neg = -lim_x;

  always_comb begin
    priority if (val_q > lim_x) begin
      clamped = lim_x;
    end else if (val_q < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.result_value <= clamped[DW-1:0];
      out_q.region       <= region_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.empty    = (piu_q == '0);
  assign status_o.t_le_rd  = (t_q <= rd_time);
  assign status_o.t_ge_rd  = (t_q >= rd_time);
  assign status_o.span_gt1 = (span > (AW + 1)'(1));
  assign status_o.out_busy = out_valid_q && out_stall_i;

  // the partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pli_pkg::OP_DIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  // brackets are ordered once the search has settled
  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == pli_pkg::OP_PREP) |-> (lo_idx_q < hi_idx_q))
    else $error("search bracket out of order");

endmodule

`default_nettype wire

// File: rtl/piecewise_linear_table_interpolator_top.sv
// Top level: piecewise-linear table interpolator, controller plus datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i/in_stall_o   | pli_in_t  (load or query)
//  out     | output    | out_valid_o/out_stall_i | pli_out_t (value, region)
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// A load transaction writes the table at acceptance. An empty-table query goes
// straight to the finish state; an endpoint query reads the first point and,
// unless the query is at or before it, the last point; an interior query then
// runs a binary search, a read and a compare per step on the single table read
// port, then the multiply and the one-bit-per-cycle divider.
// Reset clears the FSM, the output valid and the config registers; the table
// holds whatever it held until it is loaded. A stalled result waits in the
// output register while the next transaction is accepted and computed.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interpolator_top #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pli_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pli_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire pli_pkg::pli_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output pli_pkg::pli_out_t                   out_data_o
);

  pli_pkg::pli_cmd_t    cmd;
  pli_pkg::pli_status_t status;

  pli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pli_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // never overwrite a result still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !(out_valid_o && out_stall_i))
    else $error("result pushed over a stalled result");

  // table writes only come from an accepted load transaction
  a_load_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (in_valid_i && !in_stall_o && (in_data_i.kind == pli_pkg::KIND_LOAD)))
    else $error("table load without an accepted load");

  // table reads never coincide with an input acceptance
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> in_stall_o)
    else $error("table read while input is open");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Testbench for the piecewise-linear table interpolator: directed and random checks.
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH   = pli_pkg::MAX_POINTS_DEF;
  localparam int SETTLE_CYCLES = 120;
  localparam int DATA_W        = pli_pkg::DATA_W;
  localparam int PIU_W         = pli_pkg::PIU_W;
  localparam int LIMIT_W       = pli_pkg::LIMIT_W;
  localparam int IDX_W         = pli_pkg::IDX_W;
  localparam int CFG_IDX_W     = pli_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = pli_pkg::CFG_DATA_W;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pli_pkg::pli_in_t      in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pli_pkg::pli_out_t     out_data;

  piecewise_linear_table_interpolator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Shadow copy of the block's table and registers
  logic [DATA_W-1:0]        tbl_time  [TABLE_DEPTH];
  logic signed [DATA_W-1:0] tbl_value [TABLE_DEPTH];
  logic [PIU_W-1:0]         cfg_points = '0;
  logic [LIMIT_W-1:0]       cfg_limit  = {LIMIT_W{1'b1}};

  pli_pkg::pli_out_t awaited_results[$];
  pli_pkg::pli_out_t head_result;
  int                err_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic longint clamp_to_limit(longint v);
    longint lim;
    lim = longint'(cfg_limit);
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end
    return v;
  endfunction

  function automatic longint lerp_segment(int lo, int hi, logic [DATA_W-1:0] t);
    longint            vlo, vhi, diff;
    logic [63:0]       mag, step;
    logic [DATA_W-1:0] num, den;
    vlo  = longint'(tbl_value[lo]);
    vhi  = longint'(tbl_value[hi]);
    diff = vhi - vlo;
    mag  = (diff < 0) ? -diff : diff;
    num  = t - tbl_time[lo];
    den  = tbl_time[hi] - tbl_time[lo];
    if (den == '0) begin
      return vlo;
    end
    step = (mag * {32'b0, num}) / {32'b0, den};
    return (diff < 0) ? vlo - longint'(step) : vlo + longint'(step);
  endfunction

  function automatic pli_pkg::pli_out_t predict_query(logic [DATA_W-1:0] t);
    pli_pkg::pli_out_t r;
    int                n, lo, hi, mid;
    longint            v;
    n = (int'(cfg_points) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_points);
    v = 0;
    if (n == 0) begin
      r.region = pli_pkg::REGION_EMPTY;
    end else if (t <= tbl_time[0]) begin
      v = clamp_to_limit(longint'(tbl_value[0]));
      r.region = pli_pkg::REGION_BEFORE;
    end else if (t >= tbl_time[n-1]) begin
      v = clamp_to_limit(longint'(tbl_value[n-1]));
      r.region = pli_pkg::REGION_AFTER;
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (tbl_time[mid] <= t) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      v = clamp_to_limit(lerp_segment(lo, hi, t));
      r.region = pli_pkg::REGION_INTERIOR;
    end
    r.result_value = v[DATA_W-1:0];
    return r;
  endfunction

  // Drive one transaction and update the shadow model once it is accepted
  task automatic drive_item(input pli_pkg::pli_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (item.kind == pli_pkg::KIND_LOAD) begin
      tbl_time[item.point_index]  = item.point_time;
      tbl_value[item.point_index] = item.point_value;
    end else begin
      awaited_results.push_back(predict_query(item.query_time));
    end
  endtask

  task automatic load_point(input int slot, input logic [31:0] t, input logic [31:0] v);
    pli_pkg::pli_in_t item;
    item.kind        = pli_pkg::KIND_LOAD;
    item.point_index = slot[IDX_W-1:0];
    item.point_time  = t;
    item.point_value = v;
    item.query_time  = $urandom;
    drive_item(item);
  endtask

  task automatic query_at(input logic [31:0] t);
    pli_pkg::pli_in_t item;
    item.kind        = pli_pkg::KIND_QUERY;
    item.point_index = IDX_W'($urandom);
    item.point_time  = $urandom;
    item.point_value = $urandom;
    item.query_time  = t;
    drive_item(item);
  endtask

  // Hold off the sender until every result is out and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == pli_pkg::CFG_POINTS_IN_USE) begin
      cfg_points = data[PIU_W-1:0];
    end else begin
      cfg_limit = data[LIMIT_W-1:0];
    end
    @(posedge clk_i);
  endtask

  // Receiver: stall at random and compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result: value %h region %0d", $time,
                 out_data.result_value, out_data.region);
        err_count++;
      end else begin
        head_result = awaited_results.pop_front();
        if (out_data.result_value !== head_result.result_value) begin
          $display("%0t result_value mismatch: expected %h, actual %h", $time,
                   head_result.result_value, out_data.result_value);
          err_count++;
        end
        if (out_data.region !== head_result.region) begin
          $display("%0t region mismatch: expected %0d, actual %0d", $time,
                   head_result.region, out_data.region);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic test_empty_table();
    query_at(32'h0000_0000);
    query_at(32'hFFFF_FFFF);
  endtask

  task automatic test_single_point();
    load_point(0, 32'h0001_0000, 32'h7FFF_FFFF);
    wait_idle();
    cfg_write(pli_pkg::CFG_POINTS_IN_USE, CFG_DATA_W'(1));
    query_at(32'h0000_0000);
    query_at(32'h0001_0000);
    query_at(32'hFFFF_FFFF);
    // most negative value clamps to minus the default limit
    load_point(0, 32'h0001_0000, 32'h8000_0000);
    query_at(32'h0001_0001);
  endtask

  task automatic test_interior();
    load_point(0, 32'h0000_0000, 32'h8000_0000);
    load_point(1, 32'h8000_0000, 32'h7FFF_FFFF);
    load_point(2, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_idle();
    cfg_write(pli_pkg::CFG_POINTS_IN_USE, CFG_DATA_W'(3));
    query_at(32'h4000_0000);
    query_at(32'hC000_0000);
    query_at(32'h7FFF_FFFF);
    query_at(32'h8000_0000);
  endtask

  task automatic test_clamp_unsorted();
    wait_idle();
    cfg_write(pli_pkg::CFG_OUTPUT_LIMIT, '0);
    query_at(32'h4000_0000);
    query_at(32'h0000_0000);
    wait_idle();
    cfg_write(pli_pkg::CFG_OUTPUT_LIMIT, CFG_DATA_W'(32'h0001_0000));
    query_at(32'hFFFF_FFFF);
    query_at(32'h7000_0000);
    query_at(32'h1000_0000);
    // last slot earlier than slot 1: table out of order
    load_point(3, 32'h2000_0000, 32'h0000_5000);
    wait_idle();
    cfg_write(pli_pkg::CFG_OUTPUT_LIMIT, {CFG_DATA_W{1'b1}});
    cfg_write(pli_pkg::CFG_POINTS_IN_USE, CFG_DATA_W'(4));
    query_at(32'h1000_0000);
    query_at(32'h1FFF_FFFF);
    wait_idle();
    cfg_write(pli_pkg::CFG_POINTS_IN_USE, '0);
    query_at($urandom);
  endtask

  // Load slots 0..n-1 with non-decreasing times
  task automatic fill_table(input int n);
    logic [63:0] cur, inc_max;
    logic [31:0] inc_cap, v;
    int          tmode, vmode;
    tmode = int'($urandom_range(2));
    vmode = int'($urandom_range(2));
    case (tmode)
      0: begin
        cur     = 64'($urandom_range(32'h00FF_FFFF));
        inc_max = (64'hFFFF_FFFF - cur) / 64'(n);
      end
      1: begin
        cur     = 64'($urandom);
        inc_max = 64'($urandom_range(8));
      end
      default: begin
        cur     = ($urandom_range(1) != 0) ? 64'h0 : 64'($urandom_range(32'h0000_FFFF));
        inc_max = 64'($urandom_range(32'h0010_0000));
      end
    endcase
    inc_cap = (inc_max > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : inc_max[31:0];
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        cur = cur + 64'($urandom_range(inc_cap));
      end
      if (cur > 64'hFFFF_FFFF) begin
        cur = 64'hFFFF_FFFF;
      end
      if (tmode == 0 && i == n - 1 && $urandom_range(1) == 1) begin
        cur = 64'hFFFF_FFFF;
      end
      case (vmode)
        0: v = $urandom;
        1: v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
        default: begin
          case ($urandom_range(3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            default: v = $urandom;
          endcase
        end
      endcase
      load_point(i, cur[31:0], v);
    end
  endtask

  function automatic logic [31:0] pick_query_time(int n);
    int r;
    r = int'($urandom_range(99));
    if (r < 65) begin
      return $urandom_range(tbl_time[n-1], tbl_time[0]);
    end else if (r < 80) begin
      return tbl_time[$urandom_range(n - 1)];
    end else if (r < 90) begin
      return $urandom_range(tbl_time[0]);
    end
    return $urandom;
  endfunction

  task automatic run_phase(input int count, input logic [LIMIT_W-1:0] limit, input int n_items);
    logic [CFG_DATA_W-1:0] data;
    logic [31:0]           t;
    int                    n, slot;
    n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    wait_idle();
    data = ($urandom_range(1) != 0) ? CFG_DATA_W'($urandom) : '0;
    data[PIU_W-1:0] = count[PIU_W-1:0];
    cfg_write(pli_pkg::CFG_POINTS_IN_USE, data);
    cfg_write(pli_pkg::CFG_OUTPUT_LIMIT, CFG_DATA_W'(limit));
    // a clipped count reuses the full table loaded by an earlier phase
    if (count <= TABLE_DEPTH) begin
      fill_table(n);
    end
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 15) begin
        slot = int'($urandom_range(TABLE_DEPTH - 1));
        // mostly keep the time so the table stays in order
        t = (slot < n && $urandom_range(99) < 70) ? tbl_time[slot] : $urandom;
        load_point(slot, t, $urandom);
      end else begin
        query_at(pick_query_time(n));
      end
      if ($urandom_range(99) < 2) begin
        wait_idle();
      end
    end
  endtask

  task automatic test_random_traffic();
    int                 counts[12] = '{1, 2, 5, 128, 3, 16, 200, 12, 2, 33, 255, 9};
    logic [LIMIT_W-1:0] limit;
    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle_pct  = 71;
        recv_stall_pct = 12;
      end else if (p == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (p % 4)
        0: limit = {LIMIT_W{1'b1}};
        2: limit = LIMIT_W'($urandom_range(32'h0004_0000));
        default: limit = LIMIT_W'($urandom);
      endcase
      run_phase(counts[p], limit, 26);
    end
  endtask

  initial begin
    send_idle_pct  = 12;
    recv_stall_pct = 71;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_single_point();
    test_interior();
    test_clamp_unsorted();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
